@@ hw/rtl/spf_pkg.sv @@
// Shared constants, edge record and cell command types for the span filler.
package spf_pkg;

    localparam int MAX_VERTICES      = 16;
    localparam int COORD_BITS        = 12;
    localparam int FRAC_BITS         = 16;
    localparam int XW                = COORD_BITS + FRAC_BITS;
    localparam int SW                = XW + 1;
    localparam int VW                = 2 * COORD_BITS;
    localparam int IDX_W             = $clog2(MAX_VERTICES);
    localparam int CNT_W             = IDX_W + 1;
    localparam int DCNT_W            = $clog2(XW);
    localparam int OUT_W             = 12;
    localparam int MIN_POLY_VERTICES = 3;

    // Request codes
    typedef logic [1:0] req_t;
    localparam req_t REQ_VERTEX = 2'd0;
    localparam req_t REQ_CLOSE  = 2'd1;
    localparam req_t REQ_SCAN   = 2'd2;

    // One edge as held in a cell
    typedef struct packed {
        logic [XW-1:0]         xpos;
        logic [SW-1:0]         slope;
        logic [COORD_BITS-1:0] row_start;
        logic [COORD_BITS-1:0] row_end;
        logic [IDX_W-1:0]      idx;
        logic                  built;
        logic                  live;
        logic                  adv;
        logic                  tent;
    } edge_rec_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_LOAD,
        CELL_ACTIVATE,
        CELL_SORT,
        CELL_ROTATE,
        CELL_DROP_TENT,
        CELL_ADVANCE
    } cell_op_t;

    // Command broadcast from the sequencer to every cell
    typedef struct packed {
        cell_op_t              op;
        logic                  parity;
        logic                  clr_tent;
        logic [IDX_W-1:0]      load_pos;
        logic [COORD_BITS-1:0] row;
        edge_rec_t             load_rec;
    } cell_cmd_t;

    // Chain order: live edges by x then slope, then idle edges by index
    function automatic logic edge_before(edge_rec_t a, edge_rec_t b);
        logic r;
        if (a.live != b.live)
            r = a.live;
        else if (!a.live)
            r = (a.idx < b.idx);
        else if (a.xpos != b.xpos)
            r = ($signed(a.xpos) < $signed(b.xpos));
        else
            r = ($signed(a.slope) < $signed(b.slope));
        return r;
    endfunction

endpackage

@@ hw/rtl/spf_div.sv @@
// Restoring divider, one quotient bit per cycle, for edge slopes.
module spf_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [spf_pkg::XW-1:0]         dividend,
    input  logic [spf_pkg::COORD_BITS-1:0] divisor,
    output logic                           done,
    output logic [spf_pkg::XW-1:0]         quotient
);
    import spf_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DCNT_W-1:0]     cnt_reg, cnt_next;
    logic [XW-1:0]         q_reg, q_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] dvs_reg, dvs_next;
    logic [COORD_BITS:0]   shifted;
    logic [COORD_BITS:0]   diff;
    logic                  ge;

    // One trial subtraction per cycle
    always_comb
    begin
        shifted   = {rem_reg, q_reg[XW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[XW-2:0], ge};
            rem_next = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(XW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hw/rtl/spf_cell.sv @@
// One edge cell of the chain: clear, load, activate, neighbor sort, rotate, drop tentative, advance.
module spf_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spf_pkg::cell_cmd_t        cmd,
    input  logic [spf_pkg::IDX_W-1:0] pos,
    input  spf_pkg::edge_rec_t        left_rec,
    input  spf_pkg::edge_rec_t        right_rec,
    input  logic                      swap_in,
    output logic                      swap_out,
    output spf_pkg::edge_rec_t        rec
);
    import spf_pkg::*;

    edge_rec_t rec_reg, rec_next;
    logic      lead;

    // This cell leads the compare pair (pos, pos+1) on matching parity
    assign lead     = (pos[0] == cmd.parity) && (pos != IDX_W'(MAX_VERTICES - 1));
    assign swap_out = lead && edge_before(right_rec, rec_reg);

    always_comb
    begin
        rec_next = rec_reg;
        case (cmd.op)
            CELL_CLEAR:
            begin
                rec_next.built = 1'b0;
                rec_next.live  = 1'b0;
                rec_next.adv   = 1'b0;
                rec_next.tent  = 1'b0;
            end
            CELL_LOAD:
            begin
                if (pos == cmd.load_pos)
                begin
                    rec_next     = cmd.load_rec;
                    rec_next.idx = pos;
                end
            end
            CELL_ACTIVATE:
            begin
                if (rec_reg.built && !rec_reg.live && rec_reg.row_start == cmd.row)
                    rec_next.live = 1'b1;
            end
            CELL_SORT:
            begin
                if (swap_out)
                    rec_next = right_rec;
                else if (swap_in)
                    rec_next = left_rec;
            end
            CELL_ROTATE:
            begin
                rec_next = right_rec;
                if (cmd.clr_tent)
                    rec_next.tent = 1'b0;
            end
            CELL_DROP_TENT:
            begin
                if (rec_reg.tent)
                begin
                    rec_next.adv  = 1'b0;
                    rec_next.tent = 1'b0;
                end
            end
            CELL_ADVANCE:
            begin
                if (rec_reg.adv)
                begin
                    rec_next.xpos = rec_reg.xpos + rec_reg.slope[XW-1:0];
                    rec_next.adv  = 1'b0;
                end
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_reg <= '0;
        else
            rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

@@ hw/rtl/scanline_polygon_span_filler_core.sv @@
// Scanline polygon span filler: vertex load, slope divide, cell chain walk.
// Vertex or close beat: taken in ST_IDLE, and through ST_DIV when it builds an edge (28-step divider).
// Scan beat: activate, a sort pass and a rotation per cell, fix, advance, flush;
// its last span beat is registered in ST_FLUSH. Output stalls can hold the
// rotation and the flush.
// Reset (rst_n low, async) empties the polygon and returns to loading.
module scanline_polygon_span_filler_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic [spf_pkg::COORD_BITS-1:0]      vertex_x,
    input  logic [spf_pkg::COORD_BITS-1:0]      vertex_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                span_valid,
    output logic [spf_pkg::OUT_W-1:0]           span_row,
    output logic [spf_pkg::OUT_W-1:0]           span_left,
    output logic [spf_pkg::OUT_W-1:0]           span_right,
    output logic                                run_last,
    output logic                                fill_done
);
    import spf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_ACT, ST_SORT, ST_WALK, ST_FIX, ST_ADV, ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {PH_LOADING, PH_SCANNING, PH_DONE} phase_t;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [CNT_W-1:0]      vtot_reg, vtot_next;
    logic [CNT_W-1:0]      etot_reg, etot_next;
    logic [VW-1:0]         first_reg, first_next;
    logic [VW-1:0]         prev_reg, prev_next;
    logic [COORD_BITS-1:0] scan_row_reg, scan_row_next;
    logic [COORD_BITS-1:0] row_min_reg, row_min_next;
    logic [COORD_BITS-1:0] row_max_reg, row_max_next;
    logic [COORD_BITS-1:0] cur_row_reg, cur_row_next;
    logic                  fin_reg, fin_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    logic                  close_reg, close_next;
    logic [COORD_BITS-1:0] bld_xlo_reg, bld_xlo_next;
    logic [COORD_BITS-1:0] bld_ylo_reg, bld_ylo_next;
    logic [COORD_BITS-1:0] bld_yhi_reg, bld_yhi_next;
    logic                  bld_neg_reg, bld_neg_next;
    logic                  pend_reg, pend_next;
    logic [COORD_BITS-1:0] pend_x_reg, pend_x_next;
    logic                  held_vld_reg, held_vld_next;
    logic                  held_sv_reg, held_sv_next;
    logic [OUT_W-1:0]      held_l_reg, held_l_next;
    logic [OUT_W-1:0]      held_r_reg, held_r_next;
    logic                  ov_reg, ov_next;
    logic                  osv_reg, osv_next;
    logic [OUT_W-1:0]      orow_reg, orow_next;
    logic [OUT_W-1:0]      ol_reg, ol_next;
    logic [OUT_W-1:0]      or_reg, or_next;
    logic                  olast_reg, olast_next;
    logic                  odone_reg, odone_next;

    // Edge build operands
    logic [COORD_BITS-1:0] ea_x, ea_y, eb_x, eb_y;
    logic [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS-1:0] dx_mag;
    logic                  need_build;
    logic                  div_start, div_done;
    logic [XW-1:0]         div_q;
    logic [SW-1:0]         slope_pos;

    // Chain
    cell_cmd_t             cmd;
    edge_rec_t             head_mod;
    edge_rec_t             recs [MAX_VERTICES];
    logic                  swaps [MAX_VERTICES];
    edge_rec_t             head;
    logic [COORD_BITS-1:0] head_int;
    logic                  in_acc, out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !ov_reg || !out_stall;
    assign head     = recs[0];
    assign head_int = head.xpos[XW-1:FRAC_BITS];

    // Endpoints of the edge to build: prev to new vertex, or prev to first
    always_comb
    begin
        ea_x = prev_reg[COORD_BITS-1:0];
        ea_y = prev_reg[VW-1:COORD_BITS];
        if (req_type == REQ_CLOSE)
        begin
            eb_x = first_reg[COORD_BITS-1:0];
            eb_y = first_reg[VW-1:COORD_BITS];
        end
        else
        begin
            eb_x = vertex_x;
            eb_y = vertex_y;
        end
        if (ea_y < eb_y)
        begin
            lo_x = ea_x; lo_y = ea_y; hi_x = eb_x; hi_y = eb_y;
        end
        else
        begin
            lo_x = eb_x; lo_y = eb_y; hi_x = ea_x; hi_y = ea_y;
        end
        dx         = {1'b0, hi_x} - {1'b0, lo_x};
        dx_mag     = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        need_build = (ea_y != eb_y) && (etot_reg < CNT_W'(MAX_VERTICES));
    end

    spf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({dx_mag, {FRAC_BITS{1'b0}}}),
        .divisor  (hi_y - lo_y),
        .done     (div_done),
        .quotient (div_q)
    );

    assign slope_pos = {1'b0, div_q};

    // Cell chain: each cell trades with its neighbors, the tail takes the head
    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        spf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .pos       (IDX_W'(i)),
            .left_rec  ((i == 0) ? recs[0] : recs[(i + MAX_VERTICES - 1) % MAX_VERTICES]),
            .right_rec ((i == MAX_VERTICES - 1) ? head_mod : recs[(i + 1) % MAX_VERTICES]),
            .swap_in   ((i == 0) ? 1'b0 : swaps[(i + MAX_VERTICES - 1) % MAX_VERTICES]),
            .swap_out  (swaps[i]),
            .rec       (recs[i])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        vtot_next     = vtot_reg;
        etot_next     = etot_reg;
        first_next    = first_reg;
        prev_next     = prev_reg;
        scan_row_next = scan_row_reg;
        row_min_next  = row_min_reg;
        row_max_next  = row_max_reg;
        cur_row_next  = cur_row_reg;
        fin_next      = fin_reg;
        cnt_next      = cnt_reg;
        close_next    = close_reg;
        bld_xlo_next  = bld_xlo_reg;
        bld_ylo_next  = bld_ylo_reg;
        bld_yhi_next  = bld_yhi_reg;
        bld_neg_next  = bld_neg_reg;
        pend_next     = pend_reg;
        pend_x_next   = pend_x_reg;
        held_vld_next = held_vld_reg;
        held_sv_next  = held_sv_reg;
        held_l_next   = held_l_reg;
        held_r_next   = held_r_reg;
        ov_next       = ov_reg && out_stall;
        osv_next      = osv_reg;
        orow_next     = orow_reg;
        ol_next       = ol_reg;
        or_next       = or_reg;
        olast_next    = olast_reg;
        odone_next    = odone_reg;
        div_start     = 1'b0;
        cmd           = '0;
        cmd.op        = CELL_HOLD;
        cmd.row       = cur_row_reg;
        cmd.parity    = cnt_reg[0];
        cmd.load_pos  = etot_reg[IDX_W-1:0];
        cmd.load_rec.xpos      = {bld_xlo_reg, {FRAC_BITS{1'b0}}};
        cmd.load_rec.slope     = bld_neg_reg ? (-slope_pos) : slope_pos;
        cmd.load_rec.row_start = bld_ylo_reg;
        cmd.load_rec.row_end   = bld_yhi_reg;
        cmd.load_rec.built     = 1'b1;
        head_mod      = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    bld_xlo_next = lo_x;
                    bld_ylo_next = lo_y;
                    bld_yhi_next = hi_y;
                    bld_neg_next = dx[COORD_BITS];
                    case (req_type)
                        REQ_VERTEX:
                        begin
                            if (phase_reg != PH_LOADING)
                            begin
                                // New polygon: drop everything, take this vertex first
                                cmd.op        = CELL_CLEAR;
                                phase_next    = PH_LOADING;
                                etot_next     = '0;
                                vtot_next     = CNT_W'(1);
                                first_next    = {vertex_y, vertex_x};
                                prev_next     = {vertex_y, vertex_x};
                                row_min_next  = vertex_y;
                                row_max_next  = vertex_y;
                                scan_row_next = '0;
                            end
                            else if (vtot_reg < CNT_W'(MAX_VERTICES))
                            begin
                                prev_next = {vertex_y, vertex_x};
                                vtot_next = vtot_reg + 1'b1;
                                if (vtot_reg == '0)
                                begin
                                    first_next   = {vertex_y, vertex_x};
                                    row_min_next = vertex_y;
                                    row_max_next = vertex_y;
                                end
                                else
                                begin
                                    if (vertex_y < row_min_reg)
                                        row_min_next = vertex_y;
                                    if (vertex_y > row_max_reg)
                                        row_max_next = vertex_y;
                                    if (need_build)
                                    begin
                                        div_start  = 1'b1;
                                        close_next = 1'b0;
                                        state_next = ST_DIV;
                                    end
                                end
                            end
                        end
                        REQ_CLOSE:
                        begin
                            if (phase_reg == PH_LOADING)
                            begin
                                if (vtot_reg < CNT_W'(MIN_POLY_VERTICES))
                                    phase_next = PH_DONE;
                                else if (need_build)
                                begin
                                    div_start  = 1'b1;
                                    close_next = 1'b1;
                                    state_next = ST_DIV;
                                end
                                else
                                begin
                                    scan_row_next = row_min_reg;
                                    phase_next    = PH_SCANNING;
                                end
                            end
                        end
                        default:
                        begin
                            held_sv_next = 1'b0;
                            held_l_next  = '0;
                            held_r_next  = '0;
                            cur_row_next = scan_row_reg;
                            if (phase_reg != PH_SCANNING)
                            begin
                                // No polygon: a single empty beat
                                held_vld_next = 1'b1;
                                fin_next      = 1'b1;
                                state_next    = ST_FLUSH;
                            end
                            else
                            begin
                                held_vld_next = 1'b0;
                                pend_next     = 1'b0;
                                cnt_next      = '0;
                                fin_next      = (scan_row_reg >= row_max_reg);
                                if (scan_row_reg >= row_max_reg)
                                    phase_next = PH_DONE;
                                else
                                    scan_row_next = scan_row_reg + 1'b1;
                                state_next = ST_ACT;
                            end
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    cmd.op    = CELL_LOAD;
                    etot_next = etot_reg + 1'b1;
                    if (close_reg)
                    begin
                        scan_row_next = row_min_reg;
                        phase_next    = PH_SCANNING;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ACT:
            begin
                cmd.op     = CELL_ACTIVATE;
                cnt_next   = '0;
                state_next = ST_SORT;
            end
            ST_SORT:
            begin
                cmd.op   = CELL_SORT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(MAX_VERTICES - 1))
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // Head cell is examined, then moves to the tail
                cmd.op = CELL_ROTATE;
                if (head.live && head.row_end <= cur_row_reg)
                    head_mod.live = 1'b0;
                else if (head.live && !pend_reg)
                begin
                    pend_next     = 1'b1;
                    pend_x_next   = head_int;
                    head_mod.adv  = 1'b1;
                    head_mod.tent = 1'b1;
                end
                else if (head.live)
                begin
                    if (held_vld_reg && !out_free)
                        cmd.op = CELL_HOLD;
                    else
                    begin
                        if (held_vld_reg)
                        begin
                            ov_next    = 1'b1;
                            osv_next   = held_sv_reg;
                            ol_next    = held_l_reg;
                            or_next    = held_r_reg;
                            orow_next  = OUT_W'(cur_row_reg);
                            olast_next = 1'b0;
                            odone_next = fin_reg;
                        end
                        held_vld_next = 1'b1;
                        held_sv_next  = ($signed(pend_x_reg) <= $signed(head_int));
                        held_l_next   = OUT_W'($signed(pend_x_reg));
                        held_r_next   = OUT_W'($signed(head_int));
                        pend_next     = 1'b0;
                        head_mod.adv  = 1'b1;
                        cmd.clr_tent  = 1'b1;
                    end
                end
                if (cmd.op == CELL_ROTATE)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(MAX_VERTICES - 1))
                        state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                // An unpaired edge keeps its x
                cmd.op     = CELL_DROP_TENT;
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                cmd.op     = CELL_ADVANCE;
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    osv_next   = held_vld_reg ? held_sv_reg : 1'b0;
                    ol_next    = held_vld_reg ? held_l_reg : '0;
                    or_next    = held_vld_reg ? held_r_reg : '0;
                    orow_next  = OUT_W'(cur_row_reg);
                    olast_next = 1'b1;
                    odone_next = fin_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_LOADING;
            vtot_reg     <= '0;
            etot_reg     <= '0;
            first_reg    <= '0;
            prev_reg     <= '0;
            scan_row_reg <= '0;
            row_min_reg  <= '0;
            row_max_reg  <= '0;
            cnt_reg      <= '0;
            close_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            held_vld_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            vtot_reg     <= vtot_next;
            etot_reg     <= etot_next;
            first_reg    <= first_next;
            prev_reg     <= prev_next;
            scan_row_reg <= scan_row_next;
            row_min_reg  <= row_min_next;
            row_max_reg  <= row_max_next;
            cnt_reg      <= cnt_next;
            close_reg    <= close_next;
            pend_reg     <= pend_next;
            held_vld_reg <= held_vld_next;
            ov_reg       <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_row_reg <= cur_row_next;
        fin_reg     <= fin_next;
        bld_xlo_reg <= bld_xlo_next;
        bld_ylo_reg <= bld_ylo_next;
        bld_yhi_reg <= bld_yhi_next;
        bld_neg_reg <= bld_neg_next;
        pend_x_reg  <= pend_x_next;
        held_sv_reg <= held_sv_next;
        held_l_reg  <= held_l_next;
        held_r_reg  <= held_r_next;
        osv_reg     <= osv_next;
        orow_reg    <= orow_next;
        ol_reg      <= ol_next;
        or_reg      <= or_next;
        olast_reg   <= olast_next;
        odone_reg   <= odone_next;
    end

    assign out_valid  = ov_reg;
    assign span_valid = osv_reg;
    assign span_row   = orow_reg;
    assign span_left  = ol_reg;
    assign span_right = or_reg;
    assign run_last   = olast_reg;
    assign fill_done  = odone_reg;

endmodule

@@ dv/tb_scanline_polygon_span_filler_core.sv @@
// Self-checking testbench for the scanline polygon span filler core.
module tb_scanline_polygon_span_filler_core;
    timeunit 1ns;
    timeprecision 1ps;
    import spf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 700;

    typedef enum logic [1:0] { PG_LOADING, PG_SCANNING, PG_DONE } poly_phase_t;

    typedef struct packed {
        logic              valid;
        logic [OUT_W-1:0]  row;
        logic [OUT_W-1:0]  left;
        logic [OUT_W-1:0]  right;
        logic              last;
        logic              done;
    } span_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            req_type = REQ_VERTEX;
    logic [COORD_BITS-1:0] vertex_x = '0;
    logic [COORD_BITS-1:0] vertex_y = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  span_valid;
    logic [OUT_W-1:0]      span_row;
    logic [OUT_W-1:0]      span_left;
    logic [OUT_W-1:0]      span_right;
    logic                  run_last;
    logic                  fill_done;

    scanline_polygon_span_filler_core dut (.*);

    always #4 clk = ~clk;

    // Shadow polygon state
    logic signed [XW-1:0]  pe_x[MAX_VERTICES];
    logic signed [SW-1:0]  pe_slope[MAX_VERTICES];
    logic [COORD_BITS-1:0] pe_start[MAX_VERTICES];
    logic [COORD_BITS-1:0] pe_end[MAX_VERTICES];
    bit                    pe_live[MAX_VERTICES];
    int                    pe_count;
    int                    pv_count;
    logic [COORD_BITS-1:0] first_x, first_y, last_x, last_y;
    logic [COORD_BITS-1:0] cur_row, poly_ymin, poly_ymax;
    poly_phase_t           poly_phase;
    int                    active[MAX_VERTICES];
    int                    active_n;

    span_t expected_spans[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int beats_sent = 0;
    int spans_seen = 0;
    int errors = 0;
    int cycles = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d (beat %0d)", what, got, want, spans_seen);
        errors++;
    endtask

    // Appends one predicted span beat to the tail of the queue
    function automatic void add_expected(span_t s);
        expected_spans.insert(expected_spans.size(), s);
    endfunction

    function automatic void clear_poly();
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            pe_live[i] = 1'b0;
            active[i] = 0;
        end
        pe_count = 0;
        pv_count = 0;
        active_n = 0;
        first_x = '0; first_y = '0; last_x = '0; last_y = '0;
        cur_row = '0; poly_ymin = '0; poly_ymax = '0;
    endfunction

    function automatic void add_edge(logic [11:0] xa, logic [11:0] ya,
                                     logic [11:0] xb, logic [11:0] yb);
        longint xlo, ylo, xhi, yhi, dx, mag, q;
        if (ya == yb || pe_count >= MAX_VERTICES)
            return;
        if (ya < yb)
        begin
            xlo = longint'(xa); ylo = longint'(ya); xhi = longint'(xb); yhi = longint'(yb);
        end
        else
        begin
            xlo = longint'(xb); ylo = longint'(yb); xhi = longint'(xa); yhi = longint'(ya);
        end
        dx = xhi - xlo;
        mag = ((dx < 0 ? -dx : dx) << FRAC_BITS) / (yhi - ylo);
        q = dx < 0 ? -mag : mag;
        pe_x[pe_count] = XW'(xlo << FRAC_BITS);
        pe_slope[pe_count] = q[SW-1:0];
        pe_start[pe_count] = ylo[11:0];
        pe_end[pe_count] = yhi[11:0];
        pe_live[pe_count] = 1'b0;
        pe_count++;
    endfunction

    function automatic bit edge_precedes(int a, int b);
        if (pe_x[a] != pe_x[b])
            return pe_x[a] < pe_x[b];
        return pe_slope[a] < pe_slope[b];
    endfunction

    // Works out the spans one accepted beat produces
    function automatic void predict_spans(logic [1:0] r, logic [11:0] x, logic [11:0] y);
        span_t s;
        int pend, kept, e, j, first_new;
        logic [11:0] rw;
        bit fin;
        if (r == REQ_VERTEX)
        begin
            if (poly_phase != PG_LOADING)
            begin
                clear_poly();
                poly_phase = PG_LOADING;
            end
            if (pv_count >= MAX_VERTICES)
                return;
            if (pv_count == 0)
            begin
                first_x = x; first_y = y;
                poly_ymin = y; poly_ymax = y;
            end
            else
            begin
                add_edge(last_x, last_y, x, y);
                if (y < poly_ymin) poly_ymin = y;
                if (y > poly_ymax) poly_ymax = y;
            end
            last_x = x; last_y = y;
            pv_count++;
            return;
        end
        if (r == REQ_CLOSE)
        begin
            if (poly_phase != PG_LOADING)
                return;
            if (pv_count < MIN_POLY_VERTICES)
            begin
                poly_phase = PG_DONE;
                return;
            end
            add_edge(last_x, last_y, first_x, first_y);
            cur_row = poly_ymin;
            poly_phase = PG_SCANNING;
            return;
        end
        if (poly_phase != PG_SCANNING)
        begin
            s = '{1'b0, cur_row, 12'd0, 12'd0, 1'b1, 1'b1};
            add_expected(s);
            return;
        end
        rw = cur_row;
        for (int i = 0; i < pe_count; i++)
            if (pe_start[i] == rw && !pe_live[i] && active_n < MAX_VERTICES)
            begin
                pe_live[i] = 1'b1;
                active[active_n++] = i;
            end
        for (int i = 1; i < active_n; i++)
        begin
            e = active[i];
            for (j = i; j > 0 && edge_precedes(e, active[j-1]); j--)
                active[j] = active[j-1];
            active[j] = e;
        end
        fin = rw >= poly_ymax;
        first_new = expected_spans.size();
        pend = -1;
        kept = 0;
        for (int i = 0; i < active_n; i++)
        begin
            e = active[i];
            if (pe_end[e] <= rw)
            begin
                pe_live[e] = 1'b0;
                continue;
            end
            active[kept++] = e;
            if (pend < 0)
                pend = e;
            else
            begin
                s.valid = $signed(pe_x[pend][XW-1:FRAC_BITS])
                          <= $signed(pe_x[e][XW-1:FRAC_BITS]);
                s.row = rw;
                s.left = pe_x[pend][XW-1:FRAC_BITS];
                s.right = pe_x[e][XW-1:FRAC_BITS];
                s.last = 1'b0;
                s.done = fin;
                add_expected(s);
                pe_x[pend] = pe_x[pend] + pe_slope[pend][XW-1:0];
                pe_x[e] = pe_x[e] + pe_slope[e][XW-1:0];
                pend = -1;
            end
        end
        active_n = kept;
        if (fin)
            poly_phase = PG_DONE;
        else
            cur_row = rw + 12'd1;
        if (expected_spans.size() == first_new)
        begin
            s = '{1'b0, rw, 12'd0, 12'd0, 1'b0, fin};
            add_expected(s);
        end
        expected_spans[expected_spans.size()-1].last = 1'b1;
    endfunction

    // Offers one beat, waits for acceptance, then updates the prediction
    task automatic send_beat(logic [1:0] r, logic [11:0] x, logic [11:0] y);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r;
        vertex_x <= x;
        vertex_y <= y;
        do
            @(posedge clk);
        while (in_stall);
        predict_spans(r, x, y);
        beats_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall: random, or a long hold on request
    always @(posedge clk)
    begin : recv_ctrl
        static int hold_left = 0;
        static int hold_ack = 0;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack = hold_req;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        span_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            spans_seen++;
            if (expected_spans.size() == 0)
                report_mismatch("unexpected span beat, row", span_row, -1);
            else
            begin
                w = expected_spans.pop_front();
                if (span_valid !== w.valid) report_mismatch("span_valid", span_valid, w.valid);
                if (span_row !== w.row) report_mismatch("span_row", span_row, w.row);
                if (span_left !== w.left) report_mismatch("span_left", span_left, w.left);
                if (span_right !== w.right) report_mismatch("span_right", span_right, w.right);
                if (run_last !== w.last) report_mismatch("run_last", run_last, w.last);
                if (fill_done !== w.done) report_mismatch("fill_done", fill_done, w.done);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Vertices, close, then every row plus a few extra scans
    task automatic send_polygon(int nv, int ybase, int yh, int xlo, int xhi, int extra);
        for (int i = 0; i < nv; i++)
            send_beat(REQ_VERTEX, 12'($urandom_range(xhi, xlo)),
                      12'($urandom_range(ybase + yh, ybase)));
        send_beat(REQ_CLOSE, 12'($urandom), 12'($urandom));
        for (int i = 0; i < yh + 1 + extra; i++)
            send_beat(REQ_SCAN, 12'($urandom), 12'($urandom));
    endtask

    task automatic test_directed();
        // scan and close with no polygon loaded
        send_beat(REQ_SCAN, 12'd0, 12'd0);
        send_beat(REQ_CLOSE, 12'hfff, 12'hfff);
        send_beat(REQ_SCAN, 12'hfff, 12'hfff);
        // two vertices only: nothing to fill
        send_beat(REQ_VERTEX, 12'd0, 12'd0);
        send_beat(REQ_VERTEX, 12'hfff, 12'd3);
        send_beat(REQ_CLOSE, 12'd0, 12'd0);
        send_beat(REQ_SCAN, 12'd0, 12'd0);
        // full-width triangle at the top rows, with a horizontal edge
        send_beat(REQ_VERTEX, 12'd0, 12'd4093);
        send_beat(REQ_VERTEX, 12'hfff, 12'd4093);
        send_beat(REQ_VERTEX, 12'd2730, 12'd4095);
        send_beat(REQ_CLOSE, 12'd0, 12'd0);
        send_beat(REQ_CLOSE, 12'd5, 12'd5);
        for (int i = 0; i < 4; i++)
            send_beat(REQ_SCAN, 12'd0, 12'd0);
        // bow-tie: crossing edges
        send_beat(REQ_VERTEX, 12'd10, 12'd0);
        send_beat(REQ_VERTEX, 12'd40, 12'd4);
        send_beat(REQ_VERTEX, 12'd10, 12'd4);
        send_beat(REQ_VERTEX, 12'd40, 12'd0);
        send_beat(REQ_CLOSE, 12'd0, 12'd0);
        for (int i = 0; i < 6; i++)
            send_beat(REQ_SCAN, 12'd0, 12'd0);
    endtask

    task automatic test_vertex_overflow();
        // 18 vertices: the last two are dropped
        send_polygon(18, 100, 6, 0, 4095, 1);
        send_polygon(17, 4089, 6, 2000, 2100, 0);
    endtask

    task automatic test_random(int n_beats);
        int start;
        int pick;
        start = beats_sent;
        while (beats_sent - start < n_beats)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_beat(2'($urandom_range(2)), 12'($urandom), 12'($urandom));
            else if (pick < 18)
                send_polygon($urandom_range(2, 1), $urandom_range(4095 - 4), 4, 0, 4095, 1);
            else if (pick < 22)
                send_polygon($urandom_range(18, 12), $urandom_range(4095 - 8), 8, 0, 4095, 1);
            else
                send_polygon($urandom_range(8, 3), $urandom_range(4095 - 10),
                             $urandom_range(10), 0, 4095, $urandom_range(2));
        end
    endtask

    task automatic test_long_hold();
        send_idle_pct = 0;
        hold_req++;
        send_polygon(8, 500, 10, 0, 4095, 1);
        send_polygon(5, 20, 6, 100, 300, 0);
    endtask

    task automatic test_drain_pause();
        send_polygon(6, 3000, 5, 0, 4095, 0);
        wait_drained();
        send_polygon(4, 7, 4, 0, 4095, 1);
    endtask

    initial
    begin
        clear_poly();
        poly_phase = PG_LOADING;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 71;
        test_directed();
        test_vertex_overflow();
        test_random(80);
        send_idle_pct = 71;
        recv_idle_pct = 18;
        test_random(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(50);
        test_long_hold();
        test_drain_pause();

        wait_drained();
        repeat (60) @(posedge clk);
        $display("Covered %0d input beats and %0d span beats: empty scans, degenerate",
                 beats_sent, spans_seen);
        $display("and overfull polygons, crossing edges, full-range coordinates, stalls.");
        if (errors == 0 && expected_spans.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/spf_pkg.sv
hw/rtl/spf_div.sv
hw/rtl/spf_cell.sv
hw/rtl/scanline_polygon_span_filler_core.sv
dv/tb_scanline_polygon_span_filler_core.sv
